### rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// Max priority queue package
// Operation and status codes, and the control word shared by the sorted cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic              ins;
    logic              ext;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

### rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// Max priority queue cell
// Holds one entry of the descending list and shifts with its neighbors.
// ----------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             valid,
  input  logic             prev_ge,
  input  logic [DataW-1:0] prev_entry,
  input  logic [DataW-1:0] next_entry,
  output logic             ge,
  output logic [DataW-1:0] entry
);

  logic [DataW-1:0] entry_r;
  logic [DataW-1:0] entry_nxt;

  // Equal values stay ahead of a newly inserted one.
  assign ge    = valid && ($signed(entry_r) >= $signed(ctrl.value));
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && !ge) begin
      entry_nxt = prev_ge ? ctrl.value : prev_entry;
    end else if (ctrl.ext) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### rtl/max_priority_queue.sv
// The result of an accepted item is in the output register from the next cycle.
// One item per cycle unless stalled; every cell compares against the new value at once.
// A waiting result blocks input until it is read; the output register frees as it is read.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid.
// Entry contents are not reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// Max priority queue
// Bounded queue of signed values kept in descending order in a chain of cells.
// ----------------------------------------------------------------------------
module max_priority_queue
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic [DataW-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] out_result_value,
  output logic [1:0]       out_status,
  output logic [OccW-1:0]  out_occupancy
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r;
  logic [DataW-1:0]  res_value_r, res_value_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              accept, is_empty, is_full;
  cell_ctrl_t        ctrl;
  logic [DataW-1:0]  ent [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CW+OccW-1:0] occ_wide;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(CAPACITY));

  assign ctrl.ins   = accept && (in_opcode == OP_INSERT) && !is_full;
  assign ctrl.ext   = accept && (in_opcode == OP_EXTRACT) && !is_empty;
  assign ctrl.value = in_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             c_prev_ge;
    logic [DataW-1:0] c_prev_entry, c_next_entry;
    if (i == 0) begin : g_head
      assign c_prev_ge    = 1'b1;
      assign c_prev_entry = in_value;
    end else begin : g_body
      assign c_prev_ge    = ge[i-1];
      assign c_prev_entry = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign c_next_entry = '0;
    end else begin : g_link
      assign c_next_entry = ent[i+1];
    end
    mpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (count_r > CW'(i)),
      .prev_ge    (c_prev_ge),
      .prev_entry (c_prev_entry),
      .next_entry (c_next_entry),
      .ge         (ge[i]),
      .entry      (ent[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    res_value_nxt = '0;
    status_nxt    = ST_OK;
    case (in_opcode)
      OP_INSERT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (is_empty) begin
          res_value_nxt = '1;
          status_nxt    = ST_EMPTY;
        end else begin
          res_value_nxt = ent[0];
          if (in_opcode == OP_EXTRACT) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      res_value_r <= res_value_nxt;
      status_r    <= status_nxt;
    end
  end

  assign occ_wide         = {{OccW{1'b0}}, count_r};
  assign out_valid        = out_valid_r;
  assign out_result_value = res_value_r;
  assign out_status       = status_r;
  assign out_occupancy    = occ_wide[OccW-1:0];

endmodule

### rtl/mpq_checker.sv
// ----------------------------------------------------------------------------
// Max priority queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_opcode,
  input logic [DataW-1:0] in_value,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] out_result_value,
  input logic [1:0]       out_status,
  input logic [OccW-1:0]  out_occupancy
);

  localparam logic [OccW-1:0] CapOcc = OccW'(CAPACITY);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_occupancy == '0) && (out_result_value == '1))
    else $error("Empty result is inconsistent.");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
      (out_occupancy == CapOcc) && (out_result_value == '0))
    else $error("Full result is inconsistent.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_result_value) && $stable(out_status) &&
      $stable(out_occupancy))
    else $error("Stalled result item changed.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=>
      in_valid && $stable(in_opcode) && $stable(in_value))
    else $error("Stalled input item changed.");

endmodule

bind max_priority_queue mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

### verif/tb_max_priority_queue.sv
// ----------------------------------------------------------------------------
// Max priority queue testbench
// Drives insert, extract, peek and no-op items through the valid/ready input
// and checks every result against a sorted-list predictor kept in the bench.
// Directed items cover the empty and full queue, the extreme values and ties.
// Random items follow in three idling phases. Insert bias shifts between
// bursts so that the queue swings between empty and full.
// ----------------------------------------------------------------------------
module tb_max_priority_queue;
  import mpq_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam int unsigned Items    = 1550;

  typedef struct {
    logic [DataW-1:0] result_value;
    logic [1:0]       status;
    logic [OccW-1:0]  occupancy;
  } queue_result_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [1:0]       in_opcode = OP_NOP;
  logic [DataW-1:0] in_value  = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] out_result_value;
  logic [1:0]       out_status;
  logic [OccW-1:0]  out_occupancy;

  logic signed [DataW-1:0] queue_contents[$];
  queue_result_t           pending_results[$];

  int errors        = 0;
  int checked       = 0;
  int full_drops    = 0;
  int empty_reads   = 0;
  int peak_occupied = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 61;

  always #1 clk = ~clk;

  max_priority_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_value(out_result_value),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

  // Applies one operation to the sorted list and returns the result it should give.
  function automatic queue_result_t predict_result(input logic [1:0] op,
                                                   input logic signed [DataW-1:0] value);
    queue_result_t r;
    int pos;
    r.result_value = '0;
    r.status       = ST_OK;
    case (op)
      OP_INSERT: begin
        if (queue_contents.size() >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < queue_contents.size() && queue_contents[pos] >= value) pos++;
          queue_contents.insert(pos, value);
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (queue_contents.size() == 0) begin
          r.result_value = '1;
          r.status       = ST_EMPTY;
        end else begin
          r.result_value = queue_contents[0];
          if (op == OP_EXTRACT) void'(queue_contents.pop_front());
        end
      end
      default: begin
      end
    endcase
    r.occupancy = OccW'(queue_contents.size());
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t expected;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_result(in_opcode, in_value));
        if (queue_contents.size() > peak_occupied) peak_occupied = queue_contents.size();
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("result with no item outstanding: result_value %0d status %0d occupancy %0d",
                 $signed(out_result_value), out_status, out_occupancy);
        end else begin
          expected = pending_results.pop_front();
          checked++;
          if (expected.status == ST_FULL) full_drops++;
          if (expected.status == ST_EMPTY) empty_reads++;
          if (out_result_value !== expected.result_value) begin
            errors++;
            $error("result_value: expected %0d, actual %0d",
                   $signed(expected.result_value), $signed(out_result_value));
          end
          if (out_status !== expected.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", expected.status, out_status);
          end
          if (out_occupancy !== expected.occupancy) begin
            errors++;
            $error("occupancy: expected %0d, actual %0d", expected.occupancy, out_occupancy);
          end
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [DataW-1:0] value);
    int gap;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= value;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(16) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_opcode(input int insert_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return OP_NOP;
    if (roll < 16) return OP_PEEK;
    if ($urandom_range(99) < insert_pct) return OP_INSERT;
    return OP_EXTRACT;
  endfunction

  task automatic test_empty_queue();
    send_item(OP_EXTRACT, 32'h1234_5678);
    send_item(OP_PEEK, '1);
    send_item(OP_NOP, '0);
  endtask

  task automatic test_value_extremes();
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_EXTRACT, '0);
    send_item(OP_PEEK, '0);
  endtask

  task automatic test_equal_values();
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hffff_ffff);
  endtask

  task automatic test_full_queue();
    repeat (11) send_item(OP_INSERT, $urandom());
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_PEEK, '0);
    send_item(OP_NOP, '1);
  endtask

  task automatic test_random(input int n);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) insert_pct = $urandom_range(85, 15);
      if ($urandom_range(199) == 0) wait_for_results();
      send_item(pick_opcode(insert_pct), pick_value());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_value_extremes();
    test_equal_values();
    test_full_queue();
    wait_for_results();
    test_random(Items / 3);
    send_idle_pct = 61;
    recv_idle_pct = 26;
    test_random(Items / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(Items - 2 * (Items / 3));
    wait_for_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d results under three idling mixes, peak occupancy %0d.",
             checked, peak_occupied);
    $display("Inserts dropped on a full queue: %0d; reads of an empty queue: %0d.",
             full_drops, empty_reads);
    if (errors == 0) begin
      $display("max_priority_queue verification clean");
    end else begin
      $display("max_priority_queue verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("max_priority_queue verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/mpq_pkg.sv
rtl/mpq_cell.sv
rtl/max_priority_queue.sv
rtl/mpq_checker.sv
verif/tb_max_priority_queue.sv
